// ===== hdl/uvs_pkg.sv =====
// shared types, register codes and sine table arithmetic for the uv sphere vertex generator
package uvs_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RINGS    = 2'd2;

	localparam logic [15:0] RADIUS_RST   = 16'd256;
	localparam logic [7:0]  SEGMENTS_RST = 8'd32;
	localparam logic [7:0]  RINGS_RST    = 8'd16;

	localparam int IDX_W = 17;
	localparam int POS_W = 17;
	localparam int NRM_W = 16;

	// quarter turn in q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic [IDX_W-1:0] below_index;
		logic             quad_valid;
		logic             out_of_range;
	} side_t;

	// divide by the k-th taylor denominator (2k)(2k+1)
	function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
		logic [63:0] r;
		r = '0;
		case (k)
			1:       r = v / 64'd6;
			2:       r = v / 64'd20;
			3:       r = v / 64'd42;
			4:       r = v / 64'd72;
			5:       r = v / 64'd110;
			6:       r = v / 64'd156;
			7:       r = v / 64'd210;
			8:       r = v / 64'd272;
			9:       r = v / 64'd342;
			default: r = v / 64'd420;
		endcase
		return r;
	endfunction

	// sine of i/2^tbits of a quarter turn, q1.15, elaboration time only
	function automatic logic [15:0] sine_entry(input int i, input int tbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        q;
		x    = (64'(i) * HALF_PI_Q30) >> tbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		for (int k = 1; k <= 10; k++) begin
			term = taylor_div((term * x2) >> 30, k);
			if (k % 2 == 1)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = '0;
		q = (unsigned'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767)
			q = 64'd32767;
		return q[15:0];
	endfunction

endpackage

// ===== hdl/uv_sphere_vertex_generator.sv =====
// top level of the uv sphere vertex generator
//
// one grid point (ring_index, segment_index) is taken in every clock cycle at
// which start is high; busy never rises, so a vertex stream runs at one point
// per cycle. each result comes out marked by done for exactly one cycle; the
// receiver cannot stall and must take it then. the pipeline is made of the two
// angle dividers, which retire one quotient bit per stage, followed by the
// sine rom lookup (three stages) and two multiplier stages. registers are
// written through cfg_write/cfg_index/cfg_data and must only change while no
// point is in flight.
module uv_sphere_vertex_generator
	import uvs_pkg::*;
#(
	parameter int ANGLE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_write,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// command side
	input  logic                    start,
	output logic                    busy,
	input  logic [7:0]              ring_index,
	input  logic [7:0]              segment_index,
	// result side
	output logic                    done,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [NRM_W-1:0] norm_x,
	output logic signed [NRM_W-1:0] norm_y,
	output logic signed [NRM_W-1:0] norm_z,
	output logic [IDX_W-1:0]        vertex_index,
	output logic [IDX_W-1:0]        below_index,
	output logic                    quad_valid,
	output logic                    out_of_range
);

	// divider ANGLE_BITS+1, sine lookup 3, two multiplier stages
	localparam int Lat = ANGLE_BITS + 6;

	// ---------------- configuration registers ----------------
	logic [15:0] radius_q;
	logic [7:0]  segment_count_q;
	logic [7:0]  ring_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q        <= RADIUS_RST;
			segment_count_q <= SEGMENTS_RST;
			ring_count_q    <= RINGS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RADIUS:   radius_q        <= cfg_data;
				REG_SEGMENTS: segment_count_q <= cfg_data[7:0];
				REG_RINGS:    ring_count_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// a zero count behaves as one
	logic [7:0] sc, rc;
	assign sc = (segment_count_q == 8'd0) ? 8'd1 : segment_count_q;
	assign rc = (ring_count_q == 8'd0) ? 8'd1 : ring_count_q;

	// ---------------- entry ----------------
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// grid indices and flags ride along the pipe beside the angle math
	side_t side_in;
	always_comb begin
		side_in.vertex_index = IDX_W'(ring_index) * (IDX_W'(sc) + IDX_W'(1))
			+ IDX_W'(segment_index);
		side_in.below_index  = side_in.vertex_index + IDX_W'(sc) + IDX_W'(1);
		side_in.quad_valid   = (ring_index < rc) && (segment_index < sc);
		side_in.out_of_range = (ring_index > rc) || (segment_index > sc);
	end

	side_t side_s [Lat];
	logic  vld_s  [Lat];

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < Lat; k++)
			side_s[k] <= side_s[k-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Lat; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
			for (int k = 1; k < Lat; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------- angle phases ----------------
	// phi = ring*2^(A-1)/rc is taken as ring*2^A/(2*rc)
	logic [ANGLE_BITS-1:0] phi, theta;

	uvs_div_pipe #(.FRAC_BITS(ANGLE_BITS)) u_div_phi (
		.clk (clk),
		.num (ring_index),
		.den ({rc, 1'b0}),
		.quo (phi)
	);

	// theta of a full turn wraps to zero inside the divider
	uvs_div_pipe #(.FRAC_BITS(ANGLE_BITS)) u_div_theta (
		.clk (clk),
		.num (segment_index),
		.den ({1'b0, sc}),
		.quo (theta)
	);

	// ---------------- sine and cosine ----------------
	logic signed [NRM_W-1:0] sin_phi, cos_phi, sin_theta, cos_theta;

	uvs_sine_lut #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lut_phi (
		.clk     (clk),
		.phase   (phi),
		.sin_val (sin_phi),
		.cos_val (cos_phi)
	);

	uvs_sine_lut #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lut_theta (
		.clk     (clk),
		.phase   (theta),
		.sin_val (sin_theta),
		.cos_val (cos_theta)
	);

	// ---------------- first multiplier stage: normals ----------------
	logic signed [2*NRM_W-1:0] prod_x, prod_z;
	logic signed [NRM_W+16:0]  prod_py;
	logic signed [NRM_W-1:0]   nx_s1, ny_s1, nz_s1;
	logic signed [POS_W-1:0]   py_s1;

	assign prod_x  = sin_phi * cos_theta;
	assign prod_z  = sin_phi * sin_theta;
	assign prod_py = signed'({1'b0, radius_q}) * cos_phi;

	// arithmetic shift keeps the floor of the q30 product
	always_ff @(posedge clk) begin
		nx_s1 <= prod_x[30:15];
		nz_s1 <= prod_z[30:15];
		ny_s1 <= cos_phi;
		py_s1 <= prod_py[31:15];
	end

	// ---------------- second multiplier stage: positions ----------------
	logic signed [NRM_W+16:0] prod_px, prod_pz;
	logic                     oor_last;

	assign prod_px  = signed'({1'b0, radius_q}) * nx_s1;
	assign prod_pz  = signed'({1'b0, radius_q}) * nz_s1;
	assign oor_last = side_s[Lat-2].out_of_range;

	// a point off the grid gives zeros in every field but the flag
	always_ff @(posedge clk) begin
		pos_x  <= oor_last ? '0 : prod_px[31:15];
		pos_z  <= oor_last ? '0 : prod_pz[31:15];
		pos_y  <= oor_last ? '0 : py_s1;
		norm_x <= oor_last ? '0 : nx_s1;
		norm_y <= oor_last ? '0 : ny_s1;
		norm_z <= oor_last ? '0 : nz_s1;
	end

	assign done         = vld_s[Lat-1];
	assign vertex_index = side_s[Lat-1].out_of_range ? '0 : side_s[Lat-1].vertex_index;
	assign below_index  = side_s[Lat-1].out_of_range ? '0 : side_s[Lat-1].below_index;
	assign quad_valid   = side_s[Lat-1].out_of_range ? 1'b0 : side_s[Lat-1].quad_valid;
	assign out_of_range = side_s[Lat-1].out_of_range;

	// ---------------- checks ----------------
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> norm_y == '0 && pos_x == '0 && vertex_index == '0)
		else $error("off-grid point left nonzero fields");

	a_quad_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		done && quad_valid |-> !out_of_range)
		else $error("quad flagged valid for an off-grid point");

	a_norm_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> norm_y != 16'sh8000)
		else $error("cosine left the table range");

endmodule

// ===== hdl/uvs_div_pipe.sv =====
// pipelined restoring divider giving the fractional bits of num/den, one bit per stage
module uvs_div_pipe
	import uvs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [7:0]           num,
	input  logic [8:0]           den,
	output logic [FRAC_BITS-1:0] quo
);

	logic [8:0]           rem_s [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] quo_s [FRAC_BITS+1];

	// integer step: quotient bit drops out, only the remainder goes on
	always_ff @(posedge clk) begin
		rem_s[0] <= ({1'b0, num} >= den) ? ({1'b0, num} - den) : {1'b0, num};
		quo_s[0] <= '0;
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
		logic [9:0] trial;
		logic       ge;
		assign trial = {rem_s[k-1], 1'b0};
		assign ge    = trial >= {1'b0, den};
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? 9'(trial - {1'b0, den}) : trial[8:0];
			quo_s[k] <= {quo_s[k-1][FRAC_BITS-2:0], ge};
		end
	end

	assign quo = quo_s[FRAC_BITS];

endmodule

// ===== hdl/uvs_sine_lut.sv =====
// quarter-wave sine rom giving sine and cosine of one phase, through registered address, rom and sign stages
module uvs_sine_lut
	import uvs_pkg::*;
#(
	parameter int ANGLE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                    clk,
	input  logic [ANGLE_BITS-1:0]   phase,
	output logic signed [NRM_W-1:0] sin_val,
	output logic signed [NRM_W-1:0] cos_val
);

	localparam int TabN = 1 << SINE_TABLE_BITS;
	localparam int RemW = ANGLE_BITS - 2;
	localparam int WideW = (RemW > SINE_TABLE_BITS) ? RemW : SINE_TABLE_BITS;
	localparam int ShR = (RemW >= SINE_TABLE_BITS) ? RemW - SINE_TABLE_BITS : 0;
	localparam int ShL = (RemW >= SINE_TABLE_BITS) ? 0 : SINE_TABLE_BITS - RemW;
	localparam logic [SINE_TABLE_BITS:0] TabNVal = (SINE_TABLE_BITS+1)'(TabN);

	typedef logic [NRM_W-1:0] sine_rom_t [TabN+1];

	function automatic sine_rom_t build_rom();
		sine_rom_t r;
		for (int i = 0; i <= TabN; i++)
			r[i] = sine_entry(i, SINE_TABLE_BITS);
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	function automatic logic [SINE_TABLE_BITS:0] rom_addr(input logic [ANGLE_BITS-1:0] p);
		logic [WideW-1:0]           wide;
		logic [SINE_TABLE_BITS-1:0] j;
		wide = ((WideW'(p[RemW-1:0])) >> ShR) << ShL;
		j    = wide[SINE_TABLE_BITS-1:0];
		return p[ANGLE_BITS-2] ? (TabNVal - {1'b0, j}) : {1'b0, j};
	endfunction

	logic [ANGLE_BITS-1:0]      cos_phase;
	logic [SINE_TABLE_BITS:0]   sin_addr_s1, cos_addr_s1;
	logic                       sin_neg_s1, cos_neg_s1;
	logic [NRM_W-1:0]           sin_rom_s2, cos_rom_s2;
	logic                       sin_neg_s2, cos_neg_s2;

	assign cos_phase = phase + ANGLE_BITS'(1 << (ANGLE_BITS - 2));

	always_ff @(posedge clk) begin
		sin_addr_s1 <= rom_addr(phase);
		cos_addr_s1 <= rom_addr(cos_phase);
		sin_neg_s1  <= phase[ANGLE_BITS-1];
		cos_neg_s1  <= cos_phase[ANGLE_BITS-1];
		sin_rom_s2  <= SINE_ROM[sin_addr_s1];
		cos_rom_s2  <= SINE_ROM[cos_addr_s1];
		sin_neg_s2  <= sin_neg_s1;
		cos_neg_s2  <= cos_neg_s1;
		sin_val     <= sin_neg_s2 ? -signed'(sin_rom_s2) : signed'(sin_rom_s2);
		cos_val     <= cos_neg_s2 ? -signed'(cos_rom_s2) : signed'(cos_rom_s2);
	end

endmodule

// ===== verif/uv_sphere_vertex_generator_tb.sv =====
// testbench for the uv sphere vertex generator: directed and random grid points checked against a predictor
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_tb;
	import uvs_pkg::*;

	localparam int ABITS     = 16;
	localparam int TBITS     = 10;
	localparam int TAB_SIZE  = (1 << TBITS);
	localparam int LATENCY   = ABITS + 6;
	localparam int WD_LIMIT  = 2000;

	typedef struct {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [IDX_W-1:0]        vi, bi;
		logic                    qv, oor;
	} vertex_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic start;
	logic busy;
	logic [7:0] ring_index, segment_index;
	logic done;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [NRM_W-1:0] norm_x, norm_y, norm_z;
	logic [IDX_W-1:0] vertex_index, below_index;
	logic quad_valid, out_of_range;

	uv_sphere_vertex_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.ring_index(ring_index), .segment_index(segment_index),
		.done(done),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.vertex_index(vertex_index), .below_index(below_index),
		.quad_valid(quad_valid), .out_of_range(out_of_range)
	);

	// predictor copies of the registers and the quarter-wave table
	logic [15:0] cur_radius;
	logic [7:0]  cur_segments;
	logic [7:0]  cur_rings;
	int          quarter_sine [0:TAB_SIZE];

	vertex_t pending_vertices[$];
	int      errors;
	int      sent_items;
	int      checked_items;
	int      idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// own taylor series for the table, q30
	function automatic int table_entry(input int i);
		longint unsigned x, x2, term, q;
		longint sum;
		x    = (longint'(i) * 64'd1686629713) >> TBITS;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum -= term;
			else
				sum += term;
		end
		if (sum < 0)
			sum = 0;
		q = (longint'(sum) + 16384) >> 15;
		if (q > 32767)
			q = 32767;
		return int'(q);
	endfunction

	function automatic int phase_sine(input longint unsigned phase);
		longint unsigned p, r, j;
		int quad, v;
		p    = phase & ((64'd1 << ABITS) - 1);
		quad = int'(p >> (ABITS - 2));
		r    = p & ((64'd1 << (ABITS - 2)) - 1);
		j    = (r >> (ABITS - 2 - TBITS)) & (TAB_SIZE - 1);
		v    = (quad & 1) ? quarter_sine[TAB_SIZE - j] : quarter_sine[j];
		return (quad & 2) ? -v : v;
	endfunction

	// floor division by 2^15 for signed values
	function automatic longint floor15(input longint v);
		return v >>> 15;
	endfunction

	function automatic vertex_t predict_vertex(input logic [7:0] ring, input logic [7:0] seg);
		vertex_t e;
		longint unsigned rc, sc, phi, theta, vi;
		longint sp, cp, st, ct, nx, nz;
		rc = (cur_rings == 0) ? 1 : cur_rings;
		sc = (cur_segments == 0) ? 1 : cur_segments;
		e = '{default: '0};
		if (ring > rc || seg > sc) begin
			e.oor = 1'b1;
			return e;
		end
		phi   = (longint'(ring) << (ABITS - 1)) / rc;
		theta = (longint'(seg) << ABITS) / sc;
		sp = phase_sine(phi);
		cp = phase_sine(phi + (1 << (ABITS - 2)));
		st = phase_sine(theta);
		ct = phase_sine(theta + (1 << (ABITS - 2)));
		nx = floor15(sp * ct);
		nz = floor15(sp * st);
		e.px = POS_W'(floor15(longint'(cur_radius) * nx));
		e.py = POS_W'(floor15(longint'(cur_radius) * cp));
		e.pz = POS_W'(floor15(longint'(cur_radius) * nz));
		e.nx = NRM_W'(nx);
		e.ny = NRM_W'(cp);
		e.nz = NRM_W'(nz);
		vi   = ring * (sc + 1) + seg;
		e.vi = IDX_W'(vi);
		e.bi = IDX_W'(vi + sc + 1);
		e.qv = (ring < rc && seg < sc);
		return e;
	endfunction

	// checker: each done strobe is one result transfer
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && done) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected result, vertex_index %0d", $time, vertex_index);
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				checked_items++;
				if (pos_x !== e.px) begin
					$display("%0t: pos_x exp %0d got %0d", $time, e.px, pos_x); errors++;
				end
				if (pos_y !== e.py) begin
					$display("%0t: pos_y exp %0d got %0d", $time, e.py, pos_y); errors++;
				end
				if (pos_z !== e.pz) begin
					$display("%0t: pos_z exp %0d got %0d", $time, e.pz, pos_z); errors++;
				end
				if (norm_x !== e.nx) begin
					$display("%0t: norm_x exp %0d got %0d", $time, e.nx, norm_x); errors++;
				end
				if (norm_y !== e.ny) begin
					$display("%0t: norm_y exp %0d got %0d", $time, e.ny, norm_y); errors++;
				end
				if (norm_z !== e.nz) begin
					$display("%0t: norm_z exp %0d got %0d", $time, e.nz, norm_z); errors++;
				end
				if (vertex_index !== e.vi) begin
					$display("%0t: vertex_index exp %0d got %0d", $time, e.vi, vertex_index);
					errors++;
				end
				if (below_index !== e.bi) begin
					$display("%0t: below_index exp %0d got %0d", $time, e.bi, below_index);
					errors++;
				end
				if (quad_valid !== e.qv) begin
					$display("%0t: quad_valid exp %0b got %0b", $time, e.qv, quad_valid);
					errors++;
				end
				if (out_of_range !== e.oor) begin
					$display("%0t: out_of_range exp %0b got %0b", $time, e.oor, out_of_range);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("%0t: watchdog expired, %0d results pending", $time,
				pending_vertices.size());
			$display("** uv_sphere_vertex_generator: FAILED **");
			$finish;
		end
	end

	// burst bookkeeping for the sender
	int burst_left;

	// send one grid point, with random gaps between bursts
	task automatic send_point(input logic [7:0] ring, input logic [7:0] seg);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start         <= 1'b1;
		ring_index    <= ring;
		segment_index <= seg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_vertices.insert(pending_vertices.size(), predict_vertex(ring, seg));
		sent_items++;
	endtask

	// drain all results, then let the pipeline settle
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_RADIUS:   cur_radius   = val;
			REG_SEGMENTS: cur_segments = val[7:0];
			REG_RINGS:    cur_rings    = val[7:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] rad, input logic [7:0] segs,
		input logic [7:0] rings);
		drain_pipeline();
		write_reg(REG_RADIUS, rad);
		write_reg(REG_SEGMENTS, {8'd0, segs});
		write_reg(REG_RINGS, {8'd0, rings});
		cfg_write <= 1'b0;
	endtask

	// poles, seam, field extremes and out of range at reset settings
	task automatic test_directed_reset();
		send_point(8'd0, 8'd0);
		send_point(8'd16, 8'd0);
		send_point(8'd8, 8'd32);
		send_point(8'd8, 8'd8);
		send_point(8'd16, 8'd32);
		send_point(8'd17, 8'd0);
		send_point(8'd0, 8'd33);
		send_point(8'd255, 8'd255);
		send_point(8'd15, 8'd31);
		send_point(8'd4, 8'd5);
	endtask

	// zero counts act as one, plus maximum radius and counts and a zero radius
	task automatic test_directed_extremes();
		configure(16'hFFFF, 8'd0, 8'd0);
		send_point(8'd0, 8'd0);
		send_point(8'd1, 8'd1);
		send_point(8'd0, 8'd1);
		send_point(8'd2, 8'd0);
		configure(16'hFFFF, 8'd255, 8'd255);
		send_point(8'd255, 8'd255);
		send_point(8'd128, 8'd64);
		send_point(8'd127, 8'd191);
		send_point(8'd254, 8'd254);
		configure(16'd0, 8'd1, 8'd1);
		send_point(8'd1, 8'd1);
		send_point(8'd0, 8'd0);
		send_point(8'd1, 8'd2);
	endtask

	// random points, mostly inside the grid, under several register settings
	task automatic test_random_grid(input int count);
		logic [7:0] r, s;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				configure(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) < 8) begin
				r = 8'($urandom_range(0, cur_rings));
				s = 8'($urandom_range(0, cur_segments));
			end else begin
				r = 8'($urandom_range(0, 255));
				s = 8'($urandom_range(0, 255));
			end
			send_point(r, s);
			if (n == count / 2)
				drain_pipeline();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		ring_index = '0;
		segment_index = '0;
		errors = 0;
		sent_items = 0;
		checked_items = 0;
		idle_cycles = 0;
		burst_left = 0;
		cur_radius = RADIUS_RST;
		cur_segments = SEGMENTS_RST;
		cur_rings = RINGS_RST;
		for (int i = 0; i <= TAB_SIZE; i++)
			quarter_sine[i] = table_entry(i);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_reset();
		test_directed_extremes();
		test_random_grid(400);
		drain_pipeline();

		$display("covered %0d points, %0d results checked, over poles, seam, zero counts,",
			sent_items, checked_items);
		$display("out of range points and random radius and grid settings");
		if (errors == 0 && pending_vertices.size() == 0)
			$display("** uv_sphere_vertex_generator: PASSED **");
		else
			$display("** uv_sphere_vertex_generator: FAILED **");
		$finish;
	end

endmodule
